>>> hdl/gdo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped diamond grid offset package
// Shared widths, codes, payload types and arithmetic helpers for the grid
// offset pipeline.
// ----------------------------------------------------------------------------
package gdo_pkg;

  // Coordinate width of one row or column value.
  localparam int CoordBits = 10;

  localparam int FrameW   = CoordBits + 2;      // doubled-frame value before reduction
  localparam int ModW     = CoordBits + 1;      // modulus width (twice the map width)
  localparam int DirW     = 4;
  localparam int OffXW    = CoordBits + 2;
  localparam int OffYW    = CoordBits + 1;
  localparam int HalfManW = CoordBits + 1;
  localparam int HalfSqW  = 2 * CoordBits + 2;
  localparam int DxW      = FrameW + 2;         // signed x offset with headroom
  localparam int DyW      = CoordBits + 2;      // signed y offset with headroom
  localparam int PosXW    = FrameW + 2;         // signed stepped x position
  localparam int PosYW    = CoordBits + 2;      // signed stepped y position
  localparam int SqW      = 2 * DxW;
  localparam int AbsW     = DxW + 1;

  // Split of the restoring remainder steps over the frame pipeline stages.
  localparam int ModLo1 = ((CoordBits + 1) * 2) / 3;
  localparam int ModLo2 = (CoordBits + 1) / 3;
  // Split of the column remainder steps over the two column stages.
  localparam int ColLo  = CoordBits / 2;

  // Stream word widths, padded to whole bytes.
  localparam int InFieldsW  = 4 * CoordBits + DirW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = OffXW + OffYW + HalfManW + HalfSqW + DirW + 2 + 2 * CoordBits;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Direction codes.
  localparam logic [DirW-1:0] DirN    = 4'd0;
  localparam logic [DirW-1:0] DirNe   = 4'd1;
  localparam logic [DirW-1:0] DirE    = 4'd2;
  localparam logic [DirW-1:0] DirSe   = 4'd3;
  localparam logic [DirW-1:0] DirS    = 4'd4;
  localparam logic [DirW-1:0] DirSw   = 4'd5;
  localparam logic [DirW-1:0] DirW_   = 4'd6;
  localparam logic [DirW-1:0] DirNw   = 4'd7;
  localparam logic [DirW-1:0] DirNone = 4'd8;
  localparam int NumDirs = 8;

  // Configuration register indexes and reset values.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegMapWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMapHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegXWrap     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegYWrap     = 2'd3;
  localparam logic [CoordBits-1:0] RstMapWidth  = CoordBits'(64);
  localparam logic [CoordBits-1:0] RstMapHeight = CoordBits'(64);
  localparam logic RstXWrap = 1'b1;
  localparam logic RstYWrap = 1'b0;

  typedef struct packed {
    logic [CoordBits-1:0] width;
    logic [CoordBits-1:0] height;
    logic                 x_wrap;
    logic                 y_wrap;
  } cfg_t;

  typedef struct packed {
    logic [CoordBits-1:0] from_col;
    logic [CoordBits-1:0] from_row;
    logic [CoordBits-1:0] to_col;
    logic [CoordBits-1:0] to_row;
    logic [DirW-1:0]      step_dir;
  } in_t;

  // Result of moving the origin one step.
  typedef struct packed {
    logic                    ok;
    logic signed [PosXW-1:0] col;   // (x - y) / 2 before column reduction
    logic [CoordBits-1:0]    row;
  } tile_t;

  // Frame stage output.
  typedef struct packed {
    logic [FrameW-1:0]    hx;
    logic [FrameW-1:0]    tx;
    logic [CoordBits-1:0] frm;      // origin row reduced by the map height
    logic [CoordBits-1:0] fr;
    logic [CoordBits-1:0] tc;
    logic [CoordBits-1:0] tr;
    logic [DirW-1:0]      dir;
  } frm_t;

  // Offset stage output.
  typedef struct packed {
    logic signed [DxW-1:0] dx;
    logic signed [DyW-1:0] dy;
    logic [AbsW-1:0]       habs;
    logic [SqW-1:0]        sqx;
    logic [SqW-1:0]        sqy;
    logic [DirW-1:0]       tdir;
    tile_t                 adj_tile;
    tile_t                 stp_tile;
    logic [CoordBits-1:0]  tc;
    logic [CoordBits-1:0]  tr;
  } off_t;

  // Final result word.
  typedef struct packed {
    logic [OffXW-1:0]     offset_x;
    logic [OffYW-1:0]     offset_y;
    logic [HalfManW-1:0]  half_manhattan;
    logic [HalfSqW-1:0]   half_squared;
    logic [DirW-1:0]      target_direction;
    logic                 adjacent_flag;
    logic                 step_valid;
    logic [CoordBits-1:0] step_col;
    logic [CoordBits-1:0] step_row;
  } res_t;

  function automatic logic signed [2:0] step_dx(input logic [DirW-1:0] dir);
    logic signed [2:0] d;
    unique case (dir)
      DirNe, DirSe: d = 3'sd1;
      DirE:         d = 3'sd2;
      DirSw, DirNw: d = -3'sd1;
      DirW_:        d = -3'sd2;
      default:      d = 3'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [2:0] step_dy(input logic [DirW-1:0] dir);
    logic signed [2:0] d;
    unique case (dir)
      DirN:         d = -3'sd2;
      DirNe, DirNw: d = -3'sd1;
      DirSe, DirSw: d = 3'sd1;
      DirS:         d = 3'sd2;
      default:      d = 3'sd0;
    endcase
    return d;
  endfunction

  // One restoring remainder step: subtract m shifted by k if it fits.
  // A zero modulus leaves the value unchanged.
  function automatic logic [FrameW-1:0] mod_step(input logic [FrameW-1:0] r,
                                                 input logic [ModW-1:0] m,
                                                 input int k);
    logic [31:0]       sh;
    logic [FrameW-1:0] res;
    sh  = 32'(m) << k;
    res = r;
    if (32'(r) >= sh) begin
      res = r - sh[FrameW-1:0];
    end
    return res;
  endfunction

  // Move the origin by one direction step, wrap the enabled axes and check
  // that the tile lies on the map with matching parity.
  function automatic tile_t step_tile(input cfg_t cfg,
                                      input logic [FrameW-1:0] hx,
                                      input logic [CoordBits-1:0] fr,
                                      input logic [CoordBits-1:0] frm,
                                      input logic [DirW-1:0] dir);
    tile_t                   t;
    logic signed [PosXW-1:0] x;
    logic signed [PosXW-1:0] w2;
    logic signed [PosYW-1:0] y;
    logic signed [PosYW-1:0] h;
    logic signed [PosXW-1:0] diff;
    w2 = PosXW'({cfg.width, 1'b0});
    h  = PosYW'(cfg.height);
    x  = PosXW'(hx) + PosXW'(step_dx(dir));
    if (cfg.x_wrap && (w2 != '0)) begin
      if (x < 0) begin
        x = x + w2;
      end else if (x >= w2) begin
        x = x - w2;
      end
    end
    if (cfg.y_wrap && (h != '0)) begin
      y = PosYW'(frm) + PosYW'(step_dy(dir));
      if (y < 0) begin
        y = y + h;
      end
      if (y < 0) begin
        y = y + h;
      end
      if (y >= h) begin
        y = y - h;
      end
      if (y >= h) begin
        y = y - h;
      end
    end else begin
      y = PosYW'(fr) + PosYW'(step_dy(dir));
    end
    diff  = x - PosXW'(y);
    t.ok  = (x >= 0) && (x < w2) && (y >= 0) && (y < h) && (x[0] == y[0]);
    t.col = diff >>> 1;
    t.row = y[CoordBits-1:0];
    return t;
  endfunction

endpackage

>>> hdl/gdo_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid offset frame stages
// Maps both tiles to the doubled frame and reduces them, and the origin row,
// with a three-stage restoring remainder pipeline.
// ----------------------------------------------------------------------------
module gdo_frame (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gdo_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gdo_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gdo_pkg::frm_t out_o
);

  typedef struct packed {
    logic [gdo_pkg::FrameW-1:0]    rh;
    logic [gdo_pkg::FrameW-1:0]    rt;
    logic [gdo_pkg::FrameW-1:0]    rf;
    logic [gdo_pkg::CoordBits-1:0] fr;
    logic [gdo_pkg::CoordBits-1:0] tc;
    logic [gdo_pkg::CoordBits-1:0] tr;
    logic [gdo_pkg::DirW-1:0]      dir;
  } lane_t;

  logic  v1_q, v2_q, v3_q;
  logic  rdy1, rdy2, rdy3;
  lane_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q;
  logic [gdo_pkg::ModW-1:0] mx, my;

  assign mx = {cfg_i.width, 1'b0};
  assign my = {1'b0, cfg_i.height};

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    s1_d.rh  = gdo_pkg::FrameW'({in_i.from_col, 1'b0}) + gdo_pkg::FrameW'(in_i.from_row);
    s1_d.rt  = gdo_pkg::FrameW'({in_i.to_col, 1'b0}) + gdo_pkg::FrameW'(in_i.to_row);
    s1_d.rf  = gdo_pkg::FrameW'(in_i.from_row);
    s1_d.fr  = in_i.from_row;
    s1_d.tc  = in_i.to_col;
    s1_d.tr  = in_i.to_row;
    s1_d.dir = in_i.step_dir;
    for (int k = gdo_pkg::CoordBits; k >= gdo_pkg::ModLo1; k--) begin
      s1_d.rh = gdo_pkg::mod_step(s1_d.rh, mx, k);
      s1_d.rt = gdo_pkg::mod_step(s1_d.rt, mx, k);
      s1_d.rf = gdo_pkg::mod_step(s1_d.rf, my, k);
    end
  end

  always_comb begin
    s2_d = s1_q;
    for (int k = gdo_pkg::ModLo1 - 1; k >= gdo_pkg::ModLo2; k--) begin
      s2_d.rh = gdo_pkg::mod_step(s2_d.rh, mx, k);
      s2_d.rt = gdo_pkg::mod_step(s2_d.rt, mx, k);
      s2_d.rf = gdo_pkg::mod_step(s2_d.rf, my, k);
    end
  end

  always_comb begin
    s3_d = s2_q;
    for (int k = gdo_pkg::ModLo2 - 1; k >= 0; k--) begin
      s3_d.rh = gdo_pkg::mod_step(s3_d.rh, mx, k);
      s3_d.rt = gdo_pkg::mod_step(s3_d.rt, mx, k);
      s3_d.rf = gdo_pkg::mod_step(s3_d.rf, my, k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_o.hx    = s3_q.rh;
  assign out_o.tx    = s3_q.rt;
  assign out_o.frm   = s3_q.rf[gdo_pkg::CoordBits-1:0];
  assign out_o.fr    = s3_q.fr;
  assign out_o.tc    = s3_q.tc;
  assign out_o.tr    = s3_q.tr;
  assign out_o.dir   = s3_q.dir;

endmodule

>>> hdl/gdo_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid offset wrap and distance stages
// Forms the shortest wrapped offset, its direction and both stepped tiles,
// then the absolute sum and the two squares.
// ----------------------------------------------------------------------------
module gdo_offset (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gdo_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gdo_pkg::frm_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gdo_pkg::off_t out_o
);

  typedef struct packed {
    logic signed [gdo_pkg::DxW-1:0] dx;
    logic signed [gdo_pkg::DyW-1:0] dy;
    logic [gdo_pkg::DirW-1:0]       tdir;
    gdo_pkg::tile_t                 stp_tile;
    logic [gdo_pkg::FrameW-1:0]     hx;
    logic [gdo_pkg::CoordBits-1:0]  fr;
    logic [gdo_pkg::CoordBits-1:0]  frm;
    logic [gdo_pkg::CoordBits-1:0]  tc;
    logic [gdo_pkg::CoordBits-1:0]  tr;
  } wrap_t;

  logic          v4_q, v5_q;
  logic          rdy4, rdy5;
  wrap_t         s4_d, s4_q;
  gdo_pkg::off_t s5_d, s5_q;

  logic signed [gdo_pkg::DxW-1:0]   w2, wh;
  logic signed [gdo_pkg::DyW-1:0]   hh;
  logic signed [gdo_pkg::DxW-1:0]   ax;
  logic signed [gdo_pkg::DyW-1:0]   ay;
  logic signed [gdo_pkg::SqW-1:0]   px;
  logic signed [2*gdo_pkg::DyW-1:0] py;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign in_ready_o = rdy4;

  assign w2 = gdo_pkg::DxW'({cfg_i.width, 1'b0});
  assign wh = gdo_pkg::DxW'(cfg_i.width);
  assign hh = gdo_pkg::DyW'(cfg_i.height[gdo_pkg::CoordBits-1:1]);

  // Wrapping: 2d > p is the same as d > p/2 rounded down.
  always_comb begin
    s4_d.dx = gdo_pkg::DxW'(in_i.tx) - gdo_pkg::DxW'(in_i.hx);
    s4_d.dy = gdo_pkg::DyW'(in_i.tr) - gdo_pkg::DyW'(in_i.fr);
    if (cfg_i.x_wrap && (w2 != '0)) begin
      if (s4_d.dx > wh) begin
        s4_d.dx = s4_d.dx - w2;
      end else if (s4_d.dx < -wh) begin
        s4_d.dx = s4_d.dx + w2;
      end
    end
    if (cfg_i.y_wrap && (cfg_i.height != '0)) begin
      if (s4_d.dy > hh) begin
        s4_d.dy = s4_d.dy - gdo_pkg::DyW'(cfg_i.height);
      end else if (s4_d.dy < -hh) begin
        s4_d.dy = s4_d.dy + gdo_pkg::DyW'(cfg_i.height);
      end
    end
    s4_d.tdir = gdo_pkg::DirNone;
    for (int i = gdo_pkg::NumDirs - 1; i >= 0; i--) begin
      if ((s4_d.dx == gdo_pkg::DxW'(gdo_pkg::step_dx(gdo_pkg::DirW'(i)))) &&
          (s4_d.dy == gdo_pkg::DyW'(gdo_pkg::step_dy(gdo_pkg::DirW'(i))))) begin
        s4_d.tdir = gdo_pkg::DirW'(i);
      end
    end
    s4_d.stp_tile = gdo_pkg::step_tile(cfg_i, in_i.hx, in_i.fr, in_i.frm, in_i.dir);
    s4_d.hx  = in_i.hx;
    s4_d.fr  = in_i.fr;
    s4_d.frm = in_i.frm;
    s4_d.tc  = in_i.tc;
    s4_d.tr  = in_i.tr;
  end

  always_comb begin
    ax = (s4_q.dx < 0) ? -s4_q.dx : s4_q.dx;
    ay = (s4_q.dy < 0) ? -s4_q.dy : s4_q.dy;
    px = s4_q.dx * s4_q.dx;
    py = s4_q.dy * s4_q.dy;
    s5_d.dx       = s4_q.dx;
    s5_d.dy       = s4_q.dy;
    s5_d.habs     = gdo_pkg::AbsW'(unsigned'(ax)) + gdo_pkg::AbsW'(unsigned'(ay));
    s5_d.sqx      = unsigned'(px);
    s5_d.sqy      = gdo_pkg::SqW'(unsigned'(py));
    s5_d.tdir     = s4_q.tdir;
    s5_d.adj_tile = gdo_pkg::step_tile(cfg_i, s4_q.hx, s4_q.fr, s4_q.frm, s4_q.tdir);
    s5_d.stp_tile = s4_q.stp_tile;
    s5_d.tc       = s4_q.tc;
    s5_d.tr       = s4_q.tr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= in_valid_i;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_valid_i) s4_q <= s4_d;
    if (rdy5 && v4_q)       s5_q <= s5_d;
  end

  assign out_valid_o = v5_q;
  assign out_o       = s5_q;

endmodule

>>> hdl/gdo_col.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid offset column stages
// Reduces the stepped columns by the map width over two stages, halves the
// sums and assembles the result word.
// ----------------------------------------------------------------------------
module gdo_col (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gdo_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gdo_pkg::off_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gdo_pkg::res_t out_o
);

  typedef struct packed {
    logic [gdo_pkg::FrameW-1:0]    r;     // remainder of the column's magnitude
    logic                          neg;
    logic [gdo_pkg::CoordBits-1:0] c;
    logic                          ok;
    logic [gdo_pkg::CoordBits-1:0] row;
  } cred_t;

  typedef struct packed {
    cred_t                             adj;
    cred_t                             stp;
    logic [gdo_pkg::OffXW-1:0]         offset_x;
    logic [gdo_pkg::OffYW-1:0]         offset_y;
    logic [gdo_pkg::HalfManW-1:0]      half_man;
    logic [gdo_pkg::HalfSqW-1:0]       half_sq;
    logic [gdo_pkg::DirW-1:0]          tdir;
    logic [gdo_pkg::CoordBits-1:0]     tc;
    logic [gdo_pkg::CoordBits-1:0]     tr;
  } s6_t;

  logic          v6_q, v7_q;
  logic          rdy6, rdy7;
  s6_t           s6_d, s6_q;
  gdo_pkg::res_t s7_d, s7_q;
  logic [gdo_pkg::ModW-1:0]      mw;
  logic [gdo_pkg::SqW:0]         sq_sum;
  cred_t                         adj_f, stp_f;
  logic [gdo_pkg::CoordBits-1:0] adj_col, stp_col;

  assign rdy7       = !v7_q || out_ready_i;
  assign rdy6       = !v6_q || rdy7;
  assign in_ready_o = rdy6;

  assign mw = gdo_pkg::ModW'(cfg_i.width);

  function automatic cred_t col_start(input gdo_pkg::tile_t t,
                                      input logic [gdo_pkg::ModW-1:0] m);
    cred_t                          o;
    logic signed [gdo_pkg::PosXW-1:0] n;
    n     = (t.col < 0) ? -t.col : t.col;
    o.neg = (t.col < 0);
    o.c   = t.col[gdo_pkg::CoordBits-1:0];
    o.ok  = t.ok;
    o.row = t.row;
    o.r   = gdo_pkg::FrameW'(n[gdo_pkg::CoordBits-1:0]);
    for (int k = gdo_pkg::CoordBits - 1; k >= gdo_pkg::ColLo; k--) begin
      o.r = gdo_pkg::mod_step(o.r, m, k);
    end
    return o;
  endfunction

  function automatic cred_t col_finish(input cred_t i, input logic [gdo_pkg::ModW-1:0] m);
    cred_t o;
    o = i;
    for (int k = gdo_pkg::ColLo - 1; k >= 0; k--) begin
      o.r = gdo_pkg::mod_step(o.r, m, k);
    end
    return o;
  endfunction

  // A negative column folds back as width minus the remainder.
  function automatic logic [gdo_pkg::CoordBits-1:0] col_value(input cred_t i,
                                                   input logic [gdo_pkg::CoordBits-1:0] w);
    logic [gdo_pkg::CoordBits-1:0] v;
    if (!i.neg) begin
      v = i.c;
    end else if (i.r == '0) begin
      v = '0;
    end else begin
      v = w - i.r[gdo_pkg::CoordBits-1:0];
    end
    return v;
  endfunction

  always_comb begin
    sq_sum          = (gdo_pkg::SqW + 1)'(in_i.sqx) + (gdo_pkg::SqW + 1)'(in_i.sqy);
    s6_d.adj        = col_start(in_i.adj_tile, mw);
    s6_d.stp        = col_start(in_i.stp_tile, mw);
    s6_d.offset_x   = in_i.dx[gdo_pkg::OffXW-1:0];
    s6_d.offset_y   = in_i.dy[gdo_pkg::OffYW-1:0];
    s6_d.half_man   = in_i.habs[gdo_pkg::HalfManW:1];
    s6_d.half_sq    = sq_sum[gdo_pkg::HalfSqW:1];
    s6_d.tdir       = in_i.tdir;
    s6_d.tc         = in_i.tc;
    s6_d.tr         = in_i.tr;
  end

  always_comb begin
    adj_f   = col_finish(s6_q.adj, mw);
    stp_f   = col_finish(s6_q.stp, mw);
    adj_col = col_value(adj_f, cfg_i.width);
    stp_col = col_value(stp_f, cfg_i.width);
    s7_d.offset_x         = s6_q.offset_x;
    s7_d.offset_y         = s6_q.offset_y;
    s7_d.half_manhattan   = s6_q.half_man;
    s7_d.half_squared     = s6_q.half_sq;
    s7_d.target_direction = s6_q.tdir;
    s7_d.adjacent_flag    = (s6_q.tdir != gdo_pkg::DirNone) && adj_f.ok &&
                            (adj_col == s6_q.tc) && (adj_f.row == s6_q.tr);
    s7_d.step_valid       = stp_f.ok;
    s7_d.step_col         = stp_f.ok ? stp_col : '0;
    s7_d.step_row         = stp_f.ok ? stp_f.row : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (rdy6) v6_q <= in_valid_i;
      if (rdy7) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy6 && in_valid_i) s6_q <= s6_d;
    if (rdy7 && v6_q)       s7_q <= s7_d;
  end

  assign out_valid_o = v7_q;
  assign out_o       = s7_q;

endmodule

>>> hdl/wrapped_diamond_grid_offset_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped diamond grid offset unit
// Shortest wrapped offset, distances, neighbour direction, adjacency and a
// one-step move for pairs of map tiles, one word per clock while the output is ready.
// ----------------------------------------------------------------------------
// The unit takes one input word per clock while the output side is ready
// and returns exactly one result word for each, in order. Each word
// passes through the seven register stages:
// three stages of restoring remainder steps reduce both tiles' doubled-frame
// x values by twice the map width (and the origin row by the map height),
// two stages form the wrapped offset, the stepped tiles and the squares,
// and two more stages reduce the stepped columns by the map width. Every
// stage carries its own valid bit and moves on as soon as the stage after it
// is free, so bubbles close up behind a stalled output. A full pipeline
// takes a new word in every cycle in which the result word leaves, and
// stops its input only while the result word waits. The four map registers
// may be written only while no word is in flight.
module wrapped_diamond_grid_offset_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [gdo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gdo_pkg::CoordBits-1:0] cfg_data_i,
  // Input stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // from_col, from_row, to_col, to_row, step_dir (lowest bits first)
  input  logic [gdo_pkg::InDataW-1:0]  s_axis_tdata,
  // Result stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // offset_x, offset_y, half_manhattan, half_squared, target_direction,
  // adjacent_flag, step_valid, step_col, step_row (lowest bits first)
  output logic [gdo_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int Cb = gdo_pkg::CoordBits;

  gdo_pkg::cfg_t cfg_q;
  gdo_pkg::in_t  in_word;
  gdo_pkg::frm_t frm_word;
  gdo_pkg::off_t off_word;
  gdo_pkg::res_t res_word;
  logic          frm_valid, frm_ready;
  logic          off_valid, off_ready;

  // Map registers. The wrap flags keep only the lowest data bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= gdo_pkg::RstMapWidth;
      cfg_q.height <= gdo_pkg::RstMapHeight;
      cfg_q.x_wrap <= gdo_pkg::RstXWrap;
      cfg_q.y_wrap <= gdo_pkg::RstYWrap;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gdo_pkg::RegMapWidth:  cfg_q.width  <= cfg_data_i;
        gdo_pkg::RegMapHeight: cfg_q.height <= cfg_data_i;
        gdo_pkg::RegXWrap:     cfg_q.x_wrap <= cfg_data_i[0];
        gdo_pkg::RegYWrap:     cfg_q.y_wrap <= cfg_data_i[0];
      endcase
    end
  end

  // Unpack the input word; the top padding bits carry nothing.
  assign in_word.from_col = s_axis_tdata[Cb-1:0];
  assign in_word.from_row = s_axis_tdata[2*Cb-1:Cb];
  assign in_word.to_col   = s_axis_tdata[3*Cb-1:2*Cb];
  assign in_word.to_row   = s_axis_tdata[4*Cb-1:3*Cb];
  assign in_word.step_dir = s_axis_tdata[4*Cb+gdo_pkg::DirW-1:4*Cb];

  gdo_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (in_word),
    .out_valid_o (frm_valid),
    .out_ready_i (frm_ready),
    .out_o       (frm_word)
  );

  gdo_offset u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (frm_valid),
    .in_ready_o  (frm_ready),
    .in_i        (frm_word),
    .out_valid_o (off_valid),
    .out_ready_i (off_ready),
    .out_o       (off_word)
  );

  gdo_col u_col (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (off_valid),
    .in_ready_o  (off_ready),
    .in_i        (off_word),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res_word)
  );

  // Pack the result word, first field in the lowest bits.
  assign m_axis_tdata = gdo_pkg::OutDataW'({res_word.step_row,
                                            res_word.step_col,
                                            res_word.step_valid,
                                            res_word.adjacent_flag,
                                            res_word.target_direction,
                                            res_word.half_squared,
                                            res_word.half_manhattan,
                                            res_word.offset_y,
                                            res_word.offset_x});

  // Adjacency needs a neighbour direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_word.adjacent_flag) |->
      (res_word.target_direction != gdo_pkg::DirNone))
    else $error("adjacency reported without a neighbour direction");

  // Every unit step has a half Manhattan length of exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_word.target_direction != gdo_pkg::DirNone)) |->
      (res_word.half_manhattan == gdo_pkg::HalfManW'(1)))
    else $error("neighbour direction with a non-unit offset");

  // An off-map step reports a zero tile.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_word.step_valid) |->
      ((res_word.step_col == '0) && (res_word.step_row == '0)))
    else $error("off-map step with a nonzero tile");

  // With no result waiting, every stage can move, so input must be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output stage is empty");

endmodule
